// ----- rtl/rcrq_pkg.sv -----
// shared types, codes and helpers of the reserve/commit ring queue
package rcrq_pkg;

   localparam logic [1:0] MODE_RESERVE = 2'd0;
   localparam logic [1:0] MODE_COMMIT  = 2'd1;
   localparam logic [1:0] MODE_ENQUEUE = 2'd2;
   localparam logic [1:0] MODE_DEQUEUE = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_READY = 2'd2;

   localparam int unsigned DATA_W     = 64;
   localparam int unsigned DATA_BYTES = 8;
   localparam logic [3:0]  PAYLOAD_RESET = 4'd8;

   typedef struct packed {
      logic clear;
      logic capture;
      logic read;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } ctrl_stat_type;

   function automatic logic [DATA_W-1:0] byte_mask(input logic [3:0] n);
      logic [DATA_W-1:0] m;
      m = '0;
      for (int i = 0; i < DATA_BYTES; i++) begin
         m[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

endpackage

// ----- rtl/rcrq_ctrl.sv -----
// sequencer: clearing sweep, request capture, slot read and execute steps
module rcrq_ctrl
   import rcrq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd,
   output logic          busy
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_EXEC  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (stat.clear_last) state_in = ST_IDLE;
         ST_IDLE:  if (start) state_in = ST_READ;
         ST_READ:  state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd.clear   = (state_ff == ST_CLEAR);
      cmd.capture = (state_ff == ST_IDLE) && start;
      cmd.read    = (state_ff == ST_READ);
      cmd.exec    = (state_ff == ST_EXEC);
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- rtl/rcrq_dp.sv -----
// datapath: ring counters, slot memory with ready flags, drop counter, result word
module rcrq_dp
   import rcrq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output ctrl_stat_type       stat,
   input  logic                csr_write_enable,
   input  logic [3:0]          csr_write_data,
   input  logic [1:0]          req_mode,
   input  logic [5:0]          req_slot,
   input  logic [DATA_W-1:0]   req_data,
   input  logic [3:0]          req_length,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [5:0]          rsp_granted_slot,
   output logic [DATA_W-1:0]   rsp_read_data,
   output logic [31:0]         rsp_drop_count
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = AW + 1;
   localparam int TWO_D = 2 * DEPTH;

   // entry: ready flag on top of the payload
   logic [DATA_W:0] mem [DEPTH];

   logic [CW-1:0]     head_ff, head_in;
   logic [CW-1:0]     tail_ff, tail_in;
   logic [31:0]       drop_ff, drop_in;
   logic [3:0]        payload_ff;
   logic [AW-1:0]     clr_addr_ff;

   logic [1:0]        cap_mode_ff;
   logic [AW-1:0]     cap_addr_ff;
   logic              cap_ok_ff;
   logic [DATA_W-1:0] cap_data_ff;
   logic [3:0]        cap_length_ff;
   logic [DATA_W:0]   rd_ff;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [5:0]        rsp_granted_ff, rsp_granted_in;
   logic [DATA_W-1:0] rsp_rdata_ff, rsp_rdata_in;

   logic [AW-1:0]     head_slot, tail_slot;
   logic [CW:0]       occ;
   logic              full;
   logic [3:0]        wr_len;
   logic [DATA_W-1:0] wr_mask, merged;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [DATA_W:0]   mem_wdata;
   logic [AW-1:0]     cap_addr_in;
   logic              cap_ok_in;

   function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
      return (c == CW'(TWO_D - 1)) ? '0 : c + 1'b1;
   endfunction

   function automatic logic [AW-1:0] to_slot(input logic [CW-1:0] c);
      logic [CW-1:0] t;
      t = (c >= CW'(DEPTH)) ? c - CW'(DEPTH) : c;
      return t[AW-1:0];
   endfunction

   always_comb begin
      head_slot = to_slot(head_ff);
      tail_slot = to_slot(tail_ff);
      occ = {1'b0, tail_ff} - {1'b0, head_ff};
      if (tail_ff < head_ff) occ = occ + (CW+1)'(TWO_D);
      full = (occ >= (CW+1)'(DEPTH));
   end

   // request capture and address selection
   always_comb begin
      cap_ok_in   = 1'b1;
      cap_addr_in = head_slot;
      unique case (req_mode) inside
         MODE_RESERVE, MODE_ENQUEUE: cap_addr_in = tail_slot;
         MODE_COMMIT: begin
            cap_addr_in = AW'(req_slot);
            cap_ok_in   = ({26'd0, req_slot} < 32'(DEPTH));
         end
         MODE_DEQUEUE: cap_addr_in = head_slot;
         default: cap_addr_in = head_slot;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_mode_ff   <= req_mode;
         cap_addr_ff   <= cap_addr_in;
         cap_ok_ff     <= cap_ok_in;
         cap_data_ff   <= req_data;
         cap_length_ff <= req_length;
      end
   end

   // execute step
   always_comb begin
      wr_len  = (cap_length_ff > payload_ff) ? payload_ff : cap_length_ff;
      wr_mask = byte_mask(wr_len);
      merged  = (rd_ff[DATA_W-1:0] & ~wr_mask) | (cap_data_ff & wr_mask);

      head_in        = head_ff;
      tail_in        = tail_ff;
      drop_in        = drop_ff;
      rsp_status_in  = STATUS_OK;
      rsp_granted_in = '0;
      rsp_rdata_in   = '0;
      mem_we         = 1'b0;
      mem_waddr      = cap_addr_ff;
      mem_wdata      = {1'b1, merged};

      if (cmd.clear) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (cmd.exec) begin
         unique case (cap_mode_ff) inside
            MODE_RESERVE, MODE_ENQUEUE: begin
               if (full) begin
                  drop_in       = drop_ff + 32'd1;
                  rsp_status_in = STATUS_FULL;
               end else begin
                  tail_in        = bump(tail_ff);
                  rsp_granted_in = 6'(cap_addr_ff);
                  mem_we         = (cap_mode_ff == MODE_ENQUEUE);
               end
            end
            MODE_COMMIT: begin
               mem_we = cap_ok_ff;
            end
            MODE_DEQUEUE: begin
               if (rd_ff[DATA_W]) begin
                  mem_we       = 1'b1;
                  mem_wdata    = {1'b0, rd_ff[DATA_W-1:0]};
                  rsp_rdata_in = rd_ff[DATA_W-1:0] & byte_mask(payload_ff);
                  head_in      = bump(head_ff);
               end else begin
                  rsp_status_in = STATUS_NOT_READY;
               end
            end
            default: rsp_status_in = STATUS_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.read) rd_ff <= mem[cap_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         drop_ff      <= '0;
         payload_ff   <= PAYLOAD_RESET;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= cmd.exec;
         if (csr_write_enable) payload_ff <= csr_write_data;
         if (cmd.clear) clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_granted_ff <= rsp_granted_in;
         rsp_rdata_ff   <= rsp_rdata_in;
      end
   end

   assign stat.clear_last   = (clr_addr_ff == AW'(DEPTH - 1));
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_slot  = rsp_granted_ff;
   assign rsp_read_data     = rsp_rdata_ff;
   assign rsp_drop_count    = drop_ff;

endmodule

// ----- rtl/reserve_commit_ring_queue_core.sv -----
// top level of the reserve/commit ring queue
// A request word (req_mode, req_slot, req_data, req_length) is taken at a clock
// edge where start is high and busy is low. Modes: reserve a tail slot, commit
// data to a slot, enqueue in one step, or dequeue the head slot if it is ready.
// Every request gives exactly one result word, shown for one cycle with
// rsp_valid high: status, granted slot, dequeued data and the drop count.
// The result word is registered at the end of the execute step, and busy stays
// high until then, so no new request is taken before the last one is done.
// The three steps are capture, the registered read of the slot memory, and
// the read-modify-write of that slot.
// payload_bytes is to be written through csr_write_enable / csr_write_data only
// while busy is low; the block itself does not enforce this. It resets to 8.
// After reset the block sweeps the slot memory to zero, one slot per cycle,
// with busy high; configuration writes are still taken then.
// The result receiver cannot stall: each word must be taken in its cycle.
module reserve_commit_ring_queue_core
   import rcrq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_mode,
   input  logic [5:0]          req_slot,
   input  logic [DATA_W-1:0]   req_data,
   input  logic [3:0]          req_length,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [5:0]          rsp_granted_slot,
   output logic [DATA_W-1:0]   rsp_read_data,
   output logic [31:0]         rsp_drop_count,
   input  logic                csr_write_enable,
   input  logic [3:0]          csr_write_data
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   rcrq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   rcrq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_mode         (req_mode),
      .req_slot         (req_slot),
      .req_data         (req_data),
      .req_length       (req_length),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_read_data    (rsp_read_data),
      .rsp_drop_count   (rsp_drop_count)
   );

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("no result word three cycles after accept");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after accept");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_drop_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |->
         (rsp_drop_count == $past(rsp_drop_count) + 32'd1))
      else $error("full status without drop count step");

endmodule
